// ===== rtl/image_wipe_transition_top_defines.svh =====
// Assertion macros for the block that checks its own control.
`ifndef IMAGE_WIPE_TRANSITION_TOP_DEFINES_SVH
`define IMAGE_WIPE_TRANSITION_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define IWT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("iwt check failed");

// Next-cycle implication, checked outside reset.
`define IWT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("iwt check failed");

`endif

// ===== rtl/iwt_pkg.sv =====
package iwt_pkg;

    localparam int PIX_W  = 32;
    localparam int FRAC_W = 17;
    localparam int DIM_W  = 13;
    localparam int CNT_W  = 12;
    localparam int MUL_W  = 26;
    localparam int PROD_W = 2 * MUL_W;

    localparam logic [DIM_W-1:0] MAX_DIM = 13'd4096;

    // Wipe mode codes.
    localparam logic [1:0] MODE_LEFT    = 2'd0;
    localparam logic [1:0] MODE_BOTTOM  = 2'd1;
    localparam logic [1:0] MODE_ELLIPSE = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_MODE   = 2'd0;
    localparam logic [1:0] CFG_FRAC   = 2'd1;
    localparam logic [1:0] CFG_WIDTH  = 2'd2;
    localparam logic [1:0] CFG_HEIGHT = 2'd3;

    // Operation of the shared multiplier.
    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_UXX,
        MUL_AYY,
        MUL_UYY,
        MUL_AXX,
        MUL_NUM0,
        MUL_NUM1,
        MUL_DEN,
        MUL_PLO,
        MUL_PHI,
        MUL_EDGE
    } t_mul_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UXX,
        ST_AYY,
        ST_UYY,
        ST_AXX,
        ST_NUM0,
        ST_NUM1,
        ST_DEN,
        ST_PLO,
        ST_PHI,
        ST_EDGE,
        ST_DECIDE
    } t_state;

    typedef struct packed {
        logic    load;
        t_mul_op mul_op;
        logic    decide;
    } t_cmd;

    typedef struct packed {
        logic ellipse;
        logic out_free;
    } t_sts;

endpackage

// ===== rtl/iwt_in_if.sv =====
interface iwt_in_if;
    logic                        valid;
    logic                        ready;
    logic [iwt_pkg::PIX_W-1:0]   pixel_a;
    logic [iwt_pkg::PIX_W-1:0]   pixel_b;

    modport source (output valid, output pixel_a, output pixel_b, input ready);
    modport sink   (input valid, input pixel_a, input pixel_b, output ready);
endinterface

// ===== rtl/iwt_out_if.sv =====
interface iwt_out_if;
    logic                        valid;
    logic                        ready;
    logic [iwt_pkg::PIX_W-1:0]   pixel_out;
    logic                        took_b;
    logic                        frame_end;

    modport source (output valid, output pixel_out, output took_b, output frame_end,
                    input ready);
    modport sink   (input valid, input pixel_out, input took_b, input frame_end,
                    output ready);
endinterface

// ===== rtl/iwt_ctrl.sv =====
`include "image_wipe_transition_top_defines.svh"

module iwt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  iwt_pkg::t_sts i_sts,
    output iwt_pkg::t_cmd o_cmd
);

    iwt_pkg::t_state r_state;
    iwt_pkg::t_state n_state;
    logic            accept;

    assign accept = i_in_valid && o_in_ready;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= iwt_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands: at most one multiplier step per state.
    always_comb begin
        n_state       = r_state;
        o_in_ready    = 1'b0;
        o_cmd.load    = 1'b0;
        o_cmd.mul_op  = iwt_pkg::MUL_NONE;
        o_cmd.decide  = 1'b0;
        unique case (r_state)
            iwt_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = i_sts.ellipse ? iwt_pkg::ST_UXX : iwt_pkg::ST_EDGE;
                end
            end
            iwt_pkg::ST_UXX: begin
                o_cmd.mul_op = iwt_pkg::MUL_UXX;
                n_state = iwt_pkg::ST_AYY;
            end
            iwt_pkg::ST_AYY: begin
                o_cmd.mul_op = iwt_pkg::MUL_AYY;
                n_state = iwt_pkg::ST_UYY;
            end
            iwt_pkg::ST_UYY: begin
                o_cmd.mul_op = iwt_pkg::MUL_UYY;
                n_state = iwt_pkg::ST_AXX;
            end
            iwt_pkg::ST_AXX: begin
                o_cmd.mul_op = iwt_pkg::MUL_AXX;
                n_state = iwt_pkg::ST_NUM0;
            end
            iwt_pkg::ST_NUM0: begin
                o_cmd.mul_op = iwt_pkg::MUL_NUM0;
                n_state = iwt_pkg::ST_NUM1;
            end
            iwt_pkg::ST_NUM1: begin
                o_cmd.mul_op = iwt_pkg::MUL_NUM1;
                n_state = iwt_pkg::ST_DEN;
            end
            iwt_pkg::ST_DEN: begin
                o_cmd.mul_op = iwt_pkg::MUL_DEN;
                n_state = iwt_pkg::ST_PLO;
            end
            iwt_pkg::ST_PLO: begin
                o_cmd.mul_op = iwt_pkg::MUL_PLO;
                n_state = iwt_pkg::ST_PHI;
            end
            iwt_pkg::ST_PHI: begin
                o_cmd.mul_op = iwt_pkg::MUL_PHI;
                n_state = iwt_pkg::ST_DECIDE;
            end
            iwt_pkg::ST_EDGE: begin
                o_cmd.mul_op = iwt_pkg::MUL_EDGE;
                n_state = iwt_pkg::ST_DECIDE;
            end
            iwt_pkg::ST_DECIDE: begin
                if (i_sts.out_free) begin
                    o_cmd.decide = 1'b1;
                    n_state = iwt_pkg::ST_IDLE;
                end
            end
            default: n_state = iwt_pkg::ST_IDLE;
        endcase
    end

    // Control checks.
    `IWT_ASSERT_NEXT(a_accept_starts, accept, r_state != iwt_pkg::ST_IDLE)
    `IWT_ASSERT_NEXT(a_ellipse_path, accept && i_sts.ellipse, r_state == iwt_pkg::ST_UXX)
    `IWT_ASSERT_NOW(a_no_overwrite, o_cmd.decide, i_sts.out_free)
    `IWT_ASSERT_NEXT(a_decide_returns, o_cmd.decide, r_state == iwt_pkg::ST_IDLE)

endmodule

// ===== rtl/iwt_datapath.sv =====
module iwt_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_index,
    input  logic [iwt_pkg::FRAC_W-1:0]  i_cfg_data,
    input  logic [iwt_pkg::PIX_W-1:0]   i_pixel_a,
    input  logic [iwt_pkg::PIX_W-1:0]   i_pixel_b,
    input  iwt_pkg::t_cmd               i_cmd,
    output iwt_pkg::t_sts               o_sts,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic [iwt_pkg::PIX_W-1:0]   o_pixel_out,
    output logic                        o_took_b,
    output logic                        o_frame_end
);

    localparam int CW = iwt_pkg::CNT_W;
    localparam int DW = iwt_pkg::DIM_W;
    localparam int MW = iwt_pkg::MUL_W;

    // Configuration registers.
    logic [1:0]                 r_mode;
    logic [iwt_pkg::FRAC_W-1:0] r_frac;
    logic [DW-1:0]              r_width;
    logic [DW-1:0]              r_height;

    // Raster position.
    logic [CW-1:0] r_col;
    logic [CW-1:0] r_row;

    // Item captured at accept.
    logic [iwt_pkg::PIX_W-1:0] r_pix_a;
    logic [iwt_pkg::PIX_W-1:0] r_pix_b;
    logic                      r_fend_q;
    logic [CW-1:0]             r_pos;
    logic [DW-1:0]             r_n;
    logic [DW-1:0]             r_ux;
    logic [DW-1:0]             r_uy;
    logic [CW-1:0]             r_ax;
    logic [CW-1:0]             r_ay;

    // Multiplier results.
    logic [25:0] r_uxx;
    logic [25:0] r_uyy;
    logic [23:0] r_axx;
    logic [23:0] r_ayy;
    logic [50:0] r_num;
    logic [47:0] r_den;
    logic [39:0] r_plo;
    logic [64:0] r_prod;
    logic [28:0] r_edge_p;

    // Output register.
    logic                      r_out_valid;
    logic [iwt_pkg::PIX_W-1:0] r_pixel_out;
    logic                      r_took_b;
    logic                      r_frame_end;

    logic [DW-1:0]               w_dim;
    logic [DW-1:0]               h_dim;
    logic [CW-1:0]               wm1;
    logic [CW-1:0]               hm1;
    logic [DW-1:0]               twice_col;
    logic [DW-1:0]               twice_row;
    logic [DW-1:0]               ux;
    logic [DW-1:0]               uy;
    logic                        last_col;
    logic                        last_row;
    logic [MW-1:0]               mul_a;
    logic [MW-1:0]               mul_b;
    logic [iwt_pkg::PROD_W-1:0]  prod;
    logic [DW-1:0]               edge_q;
    logic [15:0]                 edge_r;
    logic                        edge_up;
    logic [DW:0]                 edge_pos;
    logic                        take_b;

    // Dimensions clamped to one through the maximum.
    always_comb begin
        if (r_width == '0) begin
            w_dim = DW'(1);
        end else if (r_width > iwt_pkg::MAX_DIM) begin
            w_dim = iwt_pkg::MAX_DIM;
        end else begin
            w_dim = r_width;
        end
        if (r_height == '0) begin
            h_dim = DW'(1);
        end else if (r_height > iwt_pkg::MAX_DIM) begin
            h_dim = iwt_pkg::MAX_DIM;
        end else begin
            h_dim = r_height;
        end
    end

    assign wm1 = CW'(w_dim - DW'(1));
    assign hm1 = CW'(h_dim - DW'(1));
    assign twice_col = {r_col, 1'b0};
    assign twice_row = {r_row, 1'b0};

    // Distances from the centre, in half-pixel units.
    always_comb begin
        if (twice_col >= {1'b0, wm1}) begin
            ux = twice_col - {1'b0, wm1};
        end else begin
            ux = {1'b0, wm1} - twice_col;
        end
        if (twice_row >= {1'b0, hm1}) begin
            uy = twice_row - {1'b0, hm1};
        end else begin
            uy = {1'b0, hm1} - twice_row;
        end
    end

    assign last_col = ({1'b0, r_col} + DW'(1)) >= w_dim;
    assign last_row = ({1'b0, r_row} + DW'(1)) >= h_dim;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= iwt_pkg::MODE_LEFT;
            r_frac   <= '0;
            r_width  <= DW'(1);
            r_height <= DW'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                iwt_pkg::CFG_MODE:   r_mode   <= i_cfg_data[1:0];
                iwt_pkg::CFG_FRAC:   r_frac   <= i_cfg_data;
                iwt_pkg::CFG_WIDTH:  r_width  <= i_cfg_data[DW-1:0];
                iwt_pkg::CFG_HEIGHT: r_height <= i_cfg_data[DW-1:0];
                default: ;
            endcase
        end
    end

    // Raster counters advance as each item is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_cmd.load) begin
            if (last_col) begin
                r_col <= '0;
                r_row <= last_row ? '0 : r_row + CW'(1);
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    // Capture the item and the geometry it needs.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pix_a  <= i_pixel_a;
            r_pix_b  <= i_pixel_b;
            r_fend_q <= last_col && last_row;
            r_pos    <= (r_mode == iwt_pkg::MODE_BOTTOM) ? r_row : r_col;
            r_n      <= (r_mode == iwt_pkg::MODE_BOTTOM) ? h_dim : w_dim;
            r_ux     <= (w_dim > DW'(1)) ? ux : '0;
            r_ax     <= (w_dim > DW'(1)) ? wm1 : CW'(1);
            r_uy     <= (h_dim > DW'(1)) ? uy : '0;
            r_ay     <= (h_dim > DW'(1)) ? hm1 : CW'(1);
        end
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        case (i_cmd.mul_op)
            iwt_pkg::MUL_UXX:  begin mul_a = MW'(r_ux);  mul_b = MW'(r_ux);  end
            iwt_pkg::MUL_AYY:  begin mul_a = MW'(r_ay);  mul_b = MW'(r_ay);  end
            iwt_pkg::MUL_UYY:  begin mul_a = MW'(r_uy);  mul_b = MW'(r_uy);  end
            iwt_pkg::MUL_AXX:  begin mul_a = MW'(r_ax);  mul_b = MW'(r_ax);  end
            iwt_pkg::MUL_NUM0: begin mul_a = r_uxx;      mul_b = MW'(r_ayy); end
            iwt_pkg::MUL_NUM1: begin mul_a = r_uyy;      mul_b = MW'(r_axx); end
            iwt_pkg::MUL_DEN:  begin mul_a = MW'(r_axx); mul_b = MW'(r_ayy); end
            iwt_pkg::MUL_PLO:  begin mul_a = MW'(r_frac[15:0]); mul_b = MW'(r_den[23:0]);  end
            iwt_pkg::MUL_PHI:  begin mul_a = MW'(r_frac[15:0]); mul_b = MW'(r_den[47:24]); end
            iwt_pkg::MUL_EDGE: begin mul_a = MW'(r_frac[15:0]); mul_b = MW'(r_n); end
            default:           begin mul_a = '0;         mul_b = '0;         end
        endcase
    end

    assign prod = {{MW{1'b0}}, mul_a} * {{MW{1'b0}}, mul_b};

    // Multiplier result registers; the numerator accumulates its two terms.
    always_ff @(posedge i_clk) begin
        case (i_cmd.mul_op)
            iwt_pkg::MUL_UXX:  r_uxx    <= prod[25:0];
            iwt_pkg::MUL_AYY:  r_ayy    <= prod[23:0];
            iwt_pkg::MUL_UYY:  r_uyy    <= prod[25:0];
            iwt_pkg::MUL_AXX:  r_axx    <= prod[23:0];
            iwt_pkg::MUL_NUM0: r_num    <= prod[50:0];
            iwt_pkg::MUL_NUM1: r_num    <= r_num + prod[50:0];
            iwt_pkg::MUL_DEN:  r_den    <= prod[47:0];
            iwt_pkg::MUL_PLO:  r_plo    <= prod[39:0];
            iwt_pkg::MUL_PHI:  r_prod   <= {1'b0, prod[39:0], 24'b0} + 65'(r_plo);
            iwt_pkg::MUL_EDGE: r_edge_p <= prod[28:0];
            default: ;
        endcase
    end

    // Wipe edge rounded to nearest, ties to even.
    assign edge_q   = r_edge_p[28:16];
    assign edge_r   = r_edge_p[15:0];
    assign edge_up  = (edge_r > 16'h8000) || ((edge_r == 16'h8000) && edge_q[0]);
    assign edge_pos = {1'b0, edge_q} + (DW+1)'(edge_up);

    // Mask decision. The ellipse test compares num * 65536 against f * den,
    // which equals comparing num against the rounded-up quotient.
    always_comb begin
        if (r_frac == '0) begin
            take_b = 1'b1;
        end else if (r_frac[iwt_pkg::FRAC_W-1]) begin
            take_b = 1'b0;
        end else if (r_mode == iwt_pkg::MODE_ELLIPSE) begin
            take_b = {r_num, 16'b0} >= {2'b0, r_prod};
        end else begin
            take_b = {2'b0, r_pos} >= edge_pos;
        end
    end

    // Output register, freed when the result item is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.decide) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.decide) begin
            r_pixel_out <= take_b ? r_pix_b : r_pix_a;
            r_took_b    <= take_b;
            r_frame_end <= r_fend_q;
        end
    end

    assign o_sts.ellipse  = (r_mode == iwt_pkg::MODE_ELLIPSE);
    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_pixel_out    = r_pixel_out;
    assign o_took_b       = r_took_b;
    assign o_frame_end    = r_frame_end;

endmodule

// ===== rtl/image_wipe_transition_top.sv =====
// An item is taken in state IDLE and its result is registered from state DECIDE,
// reached through EDGE in modes 0, 1 and 3 and through UXX to PHI in the ellipse
// mode. DECIDE waits for a free output register; no new item is taken before it.
// The single shared 26x26 multiplier runs one product per cycle in those states.
// Reset (synchronous, active low) clears the raster counters, sets the registers
// to mode 0, fraction 0, width 1 and height 1, and empties the output register.
module image_wipe_transition_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_index,
    input  logic [iwt_pkg::FRAC_W-1:0]  i_cfg_data,
    iwt_in_if.sink                      i_pix,
    iwt_out_if.source                   o_pix
);

    iwt_pkg::t_cmd cmd;
    iwt_pkg::t_sts sts;

    // Sequencer for the shared multiplier.
    iwt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_pix.valid),
        .o_in_ready (i_pix.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Counters, configuration, arithmetic and the output register.
    iwt_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_pixel_a   (i_pix.pixel_a),
        .i_pixel_b   (i_pix.pixel_b),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_ready (o_pix.ready),
        .o_out_valid (o_pix.valid),
        .o_pixel_out (o_pix.pixel_out),
        .o_took_b    (o_pix.took_b),
        .o_frame_end (o_pix.frame_end)
    );

endmodule

// ===== tb/image_wipe_transition_top_tb.sv =====
module image_wipe_transition_top_tb;

    // Code 3 is not a mode of its own; the block treats it as a wipe from the left.
    localparam logic [1:0] MODE_SPARE = 2'd3;

    localparam int RANDOM_ITEMS  = 550;
    localparam int SETTLE_CYCLES = 16;
    localparam logic [iwt_pkg::FRAC_W-1:0] FRAC_ONE = 17'h10000;

    typedef struct packed {
        logic [iwt_pkg::PIX_W-1:0] pixel;
        logic                      took_b;
        logic                      frame_end;
    } t_wipe_result;

    // Mirror of the wipe block: its registers, its raster counters and the
    // queue of pixels that it still owes.
    class wipe_scoreboard;
        logic [1:0]                 mode;
        logic [iwt_pkg::FRAC_W-1:0] fraction;
        logic [iwt_pkg::DIM_W-1:0]  width;
        logic [iwt_pkg::DIM_W-1:0]  height;
        logic [iwt_pkg::CNT_W-1:0]  column;
        logic [iwt_pkg::CNT_W-1:0]  row;
        t_wipe_result               expected_pixels[$];
        int                         errors;

        function void clear();
            mode     = iwt_pkg::MODE_LEFT;
            fraction = '0;
            width    = 13'd1;
            height   = 13'd1;
            column   = '0;
            row      = '0;
            errors   = 0;
            expected_pixels.delete();
        endfunction

        function void set_register(input logic [1:0] index,
                                   input logic [iwt_pkg::FRAC_W-1:0] data);
            case (index)
                iwt_pkg::CFG_MODE:   mode     = data[1:0];
                iwt_pkg::CFG_FRAC:   fraction = data;
                iwt_pkg::CFG_WIDTH:  width    = data[iwt_pkg::DIM_W-1:0];
                iwt_pkg::CFG_HEIGHT: height   = data[iwt_pkg::DIM_W-1:0];
                default: ;
            endcase
        endfunction

        // A size of 0 acts as 1, and one above the largest size acts as the largest.
        function int unsigned clamp_dim(input logic [iwt_pkg::DIM_W-1:0] d);
            if (d == 0) return 1;
            if (d > iwt_pkg::MAX_DIM) return iwt_pkg::MAX_DIM;
            return d;
        endfunction

        function int frame_pixels();
            return clamp_dim(width) * clamp_dim(height);
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction

        // Position of the wipe edge, fraction times size, rounded half to even.
        function int unsigned wipe_boundary(input int unsigned n);
            longint unsigned p, q, r;
            p = longint'(fraction) * n;
            q = p >> 16;
            r = p & 64'hFFFF;
            if (r > 64'h8000 || (r == 64'h8000 && q[0])) q = q + 1;
            return q;
        endfunction

        // Normalised elliptical distance from the centre against the fraction,
        // cross-multiplied so that it stays exact in integers.
        function logic ellipse_takes_b(input int unsigned w, input int unsigned h);
            longint          dx, dy;
            longint unsigned ax, ay, ux, uy, num, den, prod, need;
            dx = 0;
            dy = 0;
            ax = 1;
            ay = 1;
            if (w > 1) begin
                dx = 2 * longint'(column) - longint'(w - 1);
                ax = w - 1;
            end
            if (h > 1) begin
                dy = 2 * longint'(row) - longint'(h - 1);
                ay = h - 1;
            end
            ux   = (dx < 0) ? -dx : dx;
            uy   = (dy < 0) ? -dy : dy;
            num  = ux * ux * ay * ay + uy * uy * ax * ax;
            den  = ax * ax * ay * ay;
            prod = longint'(fraction) * den;
            need = (prod >> 16) + ((prod[15:0] != 0) ? 1 : 0);
            return num >= need;
        endfunction

        function void note_pixel_pair(input logic [iwt_pkg::PIX_W-1:0] a,
                                      input logic [iwt_pkg::PIX_W-1:0] b);
            int unsigned  w, h;
            logic         take_b, last_col, last_row;
            t_wipe_result res;
            w        = clamp_dim(width);
            h        = clamp_dim(height);
            last_col = (int'(column) + 1) >= w;
            last_row = (int'(row) + 1) >= h;

            if (fraction == 0)
                take_b = 1'b1;
            else if (fraction >= FRAC_ONE)
                take_b = 1'b0;
            else if (mode == iwt_pkg::MODE_BOTTOM)
                take_b = row >= wipe_boundary(h);
            else if (mode == iwt_pkg::MODE_ELLIPSE)
                take_b = ellipse_takes_b(w, h);
            else
                take_b = column >= wipe_boundary(w);

            res.pixel     = take_b ? b : a;
            res.took_b    = take_b;
            res.frame_end = last_col && last_row;
            expected_pixels.push_back(res);

            // Counters past a shrunken size end their row or frame at once.
            if (last_col) begin
                column = '0;
                row    = last_row ? '0 : row + 1'b1;
            end else begin
                column = column + 1'b1;
            end
        endfunction

        function void check_output(input logic [iwt_pkg::PIX_W-1:0] pixel,
                                   input logic took_b, input logic frame_end);
            t_wipe_result exp_res;
            if (expected_pixels.size() == 0) begin
                $error("unexpected item: pixel_out %h, took_b %b, frame_end %b",
                       pixel, took_b, frame_end);
                errors++;
                return;
            end
            exp_res = expected_pixels.pop_front();
            if (pixel !== exp_res.pixel) begin
                $error("pixel_out: expected %h, actual %h", exp_res.pixel, pixel);
                errors++;
            end
            if (took_b !== exp_res.took_b) begin
                $error("took_b: expected %b, actual %b", exp_res.took_b, took_b);
                errors++;
            end
            if (frame_end !== exp_res.frame_end) begin
                $error("frame_end: expected %b, actual %b", exp_res.frame_end, frame_end);
                errors++;
            end
        endfunction
    endclass

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_cfg_we;
    logic [1:0]                 i_cfg_index;
    logic [iwt_pkg::FRAC_W-1:0] i_cfg_data;
    logic                       steady;
    int                         stall_left;
    int                         sent;
    wipe_scoreboard             sb;

    iwt_in_if  pix_in();
    iwt_out_if pix_out();

    image_wipe_transition_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_pix       (pix_in),
        .o_pix       (pix_out)
    );

    // Clock with a period of 10.
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [iwt_pkg::PIX_W-1:0] pick_pixel();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return $urandom;
    endfunction

    // Sizes are mostly small so that whole frames pass; a few are extreme.
    function automatic logic [iwt_pkg::DIM_W-1:0] pick_dim();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 13'($urandom_range(2, 12));
        if (r < 80) return 13'd1;
        if (r < 86) return 13'd0;
        if (r < 93) return iwt_pkg::MAX_DIM;
        return 13'($urandom_range(4097, 8191));
    endfunction

    function automatic logic [iwt_pkg::FRAC_W-1:0] pick_frac();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)  return '0;
        if (r < 14) return FRAC_ONE;
        if (r < 18) return 17'($urandom_range(65537, 131071));
        if (r < 22) return 17'd1;
        if (r < 26) return 17'd65535;
        if (r < 32) return 17'h08000;
        return 17'($urandom_range(1, 65535));
    endfunction

    // Output side: ready with random stalls, or held high in steady stretches.
    always @(posedge i_clk) begin
        if (steady) begin
            pix_out.ready <= 1'b1;
            stall_left = 0;
        end else if (stall_left > 0) begin
            pix_out.ready <= 1'b0;
            stall_left = stall_left - 1;
        end else begin
            stall_left = pick_gap();
            pix_out.ready <= (stall_left == 0);
            if (stall_left > 0) stall_left = stall_left - 1;
        end
    end

    // Every accepted input item is predicted at the edge that takes it.
    always @(posedge i_clk) begin
        if (i_rst_n && pix_in.valid && pix_in.ready)
            sb.note_pixel_pair(pix_in.pixel_a, pix_in.pixel_b);
    end

    // Every accepted result is checked against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && pix_out.valid && pix_out.ready)
            sb.check_output(pix_out.pixel_out, pix_out.took_b, pix_out.frame_end);
    end

    task automatic send_pair(input logic [iwt_pkg::PIX_W-1:0] a,
                             input logic [iwt_pkg::PIX_W-1:0] b);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0) begin
            pix_in.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_in.valid   <= 1'b1;
        pix_in.pixel_a <= a;
        pix_in.pixel_b <= b;
        @(posedge i_clk);
        while (!pix_in.ready) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] index,
                             input logic [iwt_pkg::FRAC_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        sb.set_register(index, data);
    endtask

    // Writes the selected registers back to back, then drops the enable.
    task automatic load_config(input logic [3:0] sel, input logic [1:0] mode,
                               input logic [iwt_pkg::FRAC_W-1:0] frac,
                               input logic [iwt_pkg::DIM_W-1:0] width,
                               input logic [iwt_pkg::DIM_W-1:0] height);
        if (sel[0]) write_reg(iwt_pkg::CFG_MODE, 17'(mode));
        if (sel[1]) write_reg(iwt_pkg::CFG_FRAC, frac);
        if (sel[2]) write_reg(iwt_pkg::CFG_WIDTH, 17'(width));
        if (sel[3]) write_reg(iwt_pkg::CFG_HEIGHT, 17'(height));
        i_cfg_we <= 1'b0;
    endtask

    // Stops the input stream and waits until the block has delivered everything.
    // The first edge lets the last accepted item reach the scoreboard.
    task automatic drain();
        pix_in.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_random(input int count);
        repeat (count) send_pair(pick_pixel(), pick_pixel());
    endtask

    // Overall time limit.
    initial begin
        #5000000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        int n;
        sb = new;
        sb.clear();
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = iwt_pkg::CFG_MODE;
        i_cfg_data     = '0;
        pix_in.valid   = 1'b0;
        pix_in.pixel_a = '0;
        pix_in.pixel_b = '0;
        pix_out.ready  = 1'b0;
        steady         = 1'b0;
        stall_left     = 0;
        sent           = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: a fraction of zero takes B, and every pixel ends a 1x1 frame.
        send_pair('0, '1);
        send_pair('1, '0);
        send_pair(32'hAAAA_AAAA, 32'h5555_5555);
        drain();

        // Ellipse with a width of one: only the vertical term counts.
        load_config(4'hF, iwt_pkg::MODE_ELLIPSE, 17'h08000, 13'd1, 13'd5);
        send_random(5);
        drain();

        // A fraction above one takes A everywhere; a width of zero acts as one.
        load_config(4'hF, iwt_pkg::MODE_LEFT, 17'h1FFFF, 13'd0, 13'd3);
        send_random(3);
        drain();

        // Unused mode code with a width beyond the largest size.
        load_config(4'hF, MODE_SPARE, 17'h08000, 13'h1FFF, 13'd2);
        send_random(3);
        drain();

        // Shrinking the width leaves the column counter past the new row end.
        load_config(4'b0100, MODE_SPARE, 17'h08000, 13'd2, 13'd2);
        send_random(3);
        drain();

        // Row edge at exactly two and a half rows: the tie rounds to even.
        load_config(4'hF, iwt_pkg::MODE_BOTTOM, 17'h08000, 13'd1, 13'd5);
        send_random(5);
        drain();

        // Column edge at exactly two and a half columns.
        load_config(4'hF, iwt_pkg::MODE_LEFT, 17'h08000, 13'd5, 13'd1);
        send_random(5);
        drain();

        // Random phases: new settings, then a run of whole or partial frames.
        while (sent < RANDOM_ITEMS) begin
            load_config(($urandom_range(0, 1) == 0) ? 4'hF : 4'($urandom_range(1, 15)),
                        2'($urandom_range(0, 3)), pick_frac(), pick_dim(), pick_dim());
            steady = ($urandom_range(0, 4) == 0);
            if (sb.frame_pixels() <= 64) begin
                n = sb.frame_pixels() * $urandom_range(1, 3);
                if ($urandom_range(0, 3) == 0) n = $urandom_range(1, sb.frame_pixels());
            end else begin
                n = $urandom_range(5, 40);
            end
            if (n > RANDOM_ITEMS - sent + 8) n = RANDOM_ITEMS - sent + 8;
            send_random(n);
            sent += n;
            drain();
            steady = 1'b0;
        end

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/iwt_pkg.sv
rtl/iwt_in_if.sv
rtl/iwt_out_if.sv
rtl/iwt_ctrl.sv
rtl/iwt_datapath.sv
rtl/image_wipe_transition_top.sv
tb/image_wipe_transition_top_tb.sv
